@@ rtl/sig_pkg.sv @@
package sig_pkg;

    localparam int LIN_W         = 32;
    localparam int OFFSET_W      = 34;
    localparam int COORD_W       = 16;
    localparam int OUT_COORDS    = 4;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_STAGES    = LIN_W / DIV_STEP_BITS;
    localparam int TDATA_W       = 104;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_EXTENTS   = 3'd0,
        CFG_DIM_STRIDES   = 3'd1,
        CFG_DIM_COUNT     = 3'd2,
        CFG_ELEMENT_COUNT = 3'd3,
        CFG_STRIDED_MODE  = 3'd4
    } cfg_idx_t;

endpackage

@@ rtl/strided_index_generator_unit.sv @@
// Channel  | Group                      | Content (lowest bit first)
// ---------+----------------------------+--------------------------------------------------
// in       | s_tvalid s_tready s_tdata  | linear_index[31:0]
// out      | m_tvalid m_tready m_tdata  | offset[33:0] coord_0..coord_3 (16 each), 6 zero bits
//          | m_tuser                    | out_of_range
// cfg      | cfg_valid cfg_ready        | cfg_index (register number), cfg_data
//
// One item enters per cycle while the output is not held.
// Each dimension's remainder and quotient come from a restoring divider cut into
// eight stages of four quotient bits each; strides multiply in one stage, sum in the last.
// rst_n clears all valid bits and returns the configuration registers to their reset values.
// A held output freezes the whole pipe; no transfer is lost or repeated.
// cfg_ready is always high; write registers only while the pipe is empty.
module strided_index_generator_unit #(
    parameter int MAX_DIMS    = 4,
    parameter int EXTENT_BITS = 16,
    parameter int STRIDE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sig_pkg::LIN_W-1:0]    s_tdata,   // linear_index
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sig_pkg::TDATA_W-1:0]  m_tdata,   // offset, coord_0, coord_1, coord_2, coord_3
    output logic                         m_tuser,   // out_of_range
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sig_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sig_pkg::CFG_W-1:0]    cfg_data
);
    import sig_pkg::*;

    localparam int EB = EXTENT_BITS;
    localparam int SB = STRIDE_BITS;
    localparam int NS = MAX_DIMS * DIV_STAGES;
    localparam int PW = SB + EB;

    typedef struct packed {
        logic                        vld;
        logic                        err;
        logic [LIN_W-1:0]            lin;
        logic [LIN_W-1:0]            q;
        logic [EB-1:0]               r;
        logic [MAX_DIMS-1:0][EB-1:0] crd;
    } stage_t;

    // configuration registers
    logic [CFG_W-1:0] dim_extents_reg;
    logic [CFG_W-1:0] dim_strides_reg;
    logic [2:0]       dim_count_reg;
    logic [LIN_W-1:0] element_count_reg;
    logic             strided_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_extents_reg   <= 64'h0001_0001_0001_0001;
            dim_strides_reg   <= '0;
            dim_count_reg     <= 3'd1;
            element_count_reg <= 32'd1;
            strided_mode_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DIM_EXTENTS:   dim_extents_reg   <= cfg_data;
                CFG_DIM_STRIDES:   dim_strides_reg   <= cfg_data;
                CFG_DIM_COUNT:     dim_count_reg     <= cfg_data[2:0];
                CFG_ELEMENT_COUNT: element_count_reg <= cfg_data[LIN_W-1:0];
                CFG_STRIDED_MODE:  strided_mode_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // clamp the dimension count to 1..MAX_DIMS
    logic [3:0] n_eff;
    always_comb
    begin
        if (dim_count_reg == 3'd0)
            n_eff = 4'd1;
        else if ({1'b0, dim_count_reg} > 4'(MAX_DIMS))
            n_eff = 4'(MAX_DIMS);
        else
            n_eff = {1'b0, dim_count_reg};
    end

    // unpack extents and strides; fields past bit 63 read zero
    logic [MAX_DIMS-1:0][EB-1:0] ext_w;
    logic [MAX_DIMS-1:0][SB-1:0] str_w;
    logic [MAX_DIMS-1:0]         act_w;

    genvar gd;
    generate
        for (gd = 0; gd < MAX_DIMS; gd++)
        begin : g_unpack
            logic [CFG_W-1:0] esh;
            logic [CFG_W-1:0] ssh;
            if (gd * EB < CFG_W)
            begin : g_e
                assign esh = dim_extents_reg >> (gd * EB);
            end
            else
            begin : g_ez
                assign esh = '0;
            end
            if (gd * SB < CFG_W)
            begin : g_s
                assign ssh = dim_strides_reg >> (gd * SB);
            end
            else
            begin : g_sz
                assign ssh = '0;
            end
            assign ext_w[gd] = esh[EB-1:0];
            assign str_w[gd] = ssh[SB-1:0];
            assign act_w[gd] = 4'(gd) < n_eff;
        end
    endgenerate

    // global advance: move when the output register is free or being taken
    logic en;
    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    stage_t pipe_reg [0:NS];

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pipe_reg[0] <= '0;
        else if (en)
        begin
            pipe_reg[0].vld <= s_tvalid;
            pipe_reg[0].err <= s_tdata >= element_count_reg;
            pipe_reg[0].lin <= s_tdata;
            pipe_reg[0].q   <= s_tdata;
            pipe_reg[0].r   <= '0;
            pipe_reg[0].crd <= '0;
        end
    end

    // divider stages: slot j handles dimension MAX_DIMS-1-j, innermost first
    genvar gs;
    generate
        for (gs = 1; gs <= NS; gs++)
        begin : g_div
            localparam int J = (gs - 1) / DIV_STAGES;
            localparam int K = (gs - 1) % DIV_STAGES;
            localparam int D = MAX_DIMS - 1 - J;

            stage_t        cur;
            stage_t        nxt;
            logic [LIN_W-1:0] qv;
            logic [EB:0]      rw;

            assign cur = pipe_reg[gs-1];

            always_comb
            begin
                nxt = cur;
                qv  = cur.q;
                rw  = (K == 0) ? '0 : {1'b0, cur.r};
                for (int i = 0; i < DIV_STEP_BITS; i++)
                begin
                    rw = {rw[EB-1:0], qv[LIN_W-1]};
                    qv = {qv[LIN_W-2:0], 1'b0};
                    if (rw >= {1'b0, ext_w[D]})
                    begin
                        rw    = rw - {1'b0, ext_w[D]};
                        qv[0] = 1'b1;
                    end
                end
                if (act_w[D])
                begin
                    nxt.q = qv;
                    nxt.r = rw[EB-1:0];
                    if (ext_w[D] == '0)
                        nxt.err = 1'b1;
                    if (K == DIV_STAGES - 1)
                        nxt.crd[D] = rw[EB-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    pipe_reg[gs] <= '0;
                else if (en)
                    pipe_reg[gs] <= nxt;
            end
        end
    endgenerate

    // product stage
    logic                              p_vld_reg;
    logic                              p_err_reg;
    logic [LIN_W-1:0]                  p_lin_reg;
    logic [MAX_DIMS-1:0][EB-1:0]       p_crd_reg;
    logic [MAX_DIMS-1:0][OFFSET_W-1:0] p_prod_reg;
    logic [MAX_DIMS-1:0][OFFSET_W-1:0] p_prod_next;

    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
            p_prod_next[d] = OFFSET_W'(PW'(str_w[d]) * PW'(pipe_reg[NS].crd[d]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else if (en)
            p_vld_reg <= pipe_reg[NS].vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_err_reg  <= pipe_reg[NS].err;
            p_lin_reg  <= pipe_reg[NS].lin;
            p_crd_reg  <= pipe_reg[NS].crd;
            p_prod_reg <= p_prod_next;
        end
    end

    // sum, select and output register
    logic [OFFSET_W-1:0] sum_w;
    logic [OFFSET_W-1:0] o_off_next;
    logic [OUT_COORDS-1:0][COORD_W-1:0] o_crd_next;

    always_comb
    begin
        sum_w = '0;
        for (int d = 0; d < MAX_DIMS; d++)
            sum_w = sum_w + p_prod_reg[d];
        o_crd_next = '0;
        for (int k = 0; k < OUT_COORDS; k++)
        begin
            if (k < MAX_DIMS && !p_err_reg)
                o_crd_next[k] = COORD_W'(p_crd_reg[k % MAX_DIMS]);
        end
        if (p_err_reg)
            o_off_next = '0;
        else if (strided_mode_reg)
            o_off_next = sum_w;
        else
            o_off_next = OFFSET_W'(p_lin_reg);
    end

    logic                               o_vld_reg;
    logic                               o_err_reg;
    logic [OFFSET_W-1:0]                o_off_reg;
    logic [OUT_COORDS-1:0][COORD_W-1:0] o_crd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_vld_reg <= 1'b0;
        else if (en)
            o_vld_reg <= p_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_err_reg <= p_err_reg;
            o_off_reg <= o_off_next;
            o_crd_reg <= o_crd_next;
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tuser  = o_err_reg;
    assign m_tdata  = TDATA_W'({o_crd_reg, o_off_reg});

    // an error result carries no offset or coordinates
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result with non-zero payload");

    // a held result keeps its payload through the stall
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    // with one dimension in use the outer coordinates read zero
    a_unused: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && dim_count_reg <= 3'd1 |-> m_tdata[97:50] == '0)
        else $error("unused coordinate not zero");

    // input side follows the output stall
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (m_tready || !m_tvalid))
        else $error("input ready out of step with output stall");

endmodule
